// ===== rtl/cbc_pkg.sv =====
// ----------------------------------------------------------------------------
// cbc_pkg: shared types and constants of the cartridge bank controller
// bus beat formats, action codes, address region codes and config group
// ----------------------------------------------------------------------------
`default_nettype none

package cbc_pkg;

    // action codes of a result beat
    localparam logic [2:0] ACT_ABSORB   = 3'd0;
    localparam logic [2:0] ACT_OPEN_RD  = 3'd1;
    localparam logic [2:0] ACT_ROM_RD   = 3'd2;
    localparam logic [2:0] ACT_RAM_RD   = 3'd3;
    localparam logic [2:0] ACT_RAM_WR   = 3'd4;
    localparam logic [2:0] ACT_BUS_RD   = 3'd5;
    localparam logic [2:0] ACT_BUS_WR   = 3'd6;

    // access kinds
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // 8 KiB regions of the cpu map, by address bits [15:13]
    localparam logic [2:0] REG_RAM_ENABLE = 3'd0;  // 0x0000-0x1fff
    localparam logic [2:0] REG_ROM_BANK   = 3'd1;  // 0x2000-0x3fff
    localparam logic [2:0] REG_RAM_BANK   = 3'd2;  // 0x4000-0x5fff
    localparam logic [2:0] REG_LATCH      = 3'd3;  // 0x6000-0x7fff
    localparam logic [2:0] REGION_EXT_RAM = 3'd5;  // 0xa000-0xbfff

    // 16 KiB rom window 0x4000-0x7fff, by address bits [15:14]
    localparam logic [1:0] ROM_WINDOW = 2'd1;

    localparam logic [3:0] RAM_EN_KEY     = 4'hA;
    localparam logic [7:0] RAM_BANK_MAX   = 8'h07;
    localparam logic [7:0] CLOCK_SEL_MAX  = 8'h0C;
    localparam logic [7:0] OPEN_BUS_BYTE  = 8'hFF;

    // configuration register indexes
    localparam logic CFG_ROM_LOG2 = 1'b0;
    localparam logic CFG_RAM_LOG2 = 1'b1;

    localparam logic [2:0] ROM_LOG2_RESET = 3'd7;
    localparam logic [1:0] RAM_LOG2_RESET = 2'd0;

    typedef struct packed {
        logic        cmd;
        logic [15:0] bus_address;
        logic [7:0]  write_data;
    } t_in_beat;

    typedef struct packed {
        logic [2:0]  action;
        logic [20:0] mapped_address;
        logic [7:0]  data_out;
    } t_out_beat;

    typedef struct packed {
        logic [2:0] rom_bank_count_log2;
        logic [1:0] ram_bank_count_log2;
    } t_cfg;

endpackage

`default_nettype wire

// ===== rtl/cbc_mapper.sv =====
// ----------------------------------------------------------------------------
// cbc_mapper: bank state and access decode
// holds the bank registers and maps one bus access to one result beat
// ----------------------------------------------------------------------------
`default_nettype none

module cbc_mapper
    import cbc_pkg::*;
#(
    parameter int ROM_BANK_BITS  = 7,
    parameter int RAM_BANK_LIMIT = 8
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_fire,
    input  wire t_in_beat  i_beat,
    input  wire t_cfg      i_cfg,
    output t_out_beat      o_beat
);

    logic [ROM_BANK_BITS-1:0] r_rom_bank, n_rom_bank;
    logic [2:0]               r_ram_bank, n_ram_bank;
    logic                     r_ram_en,   n_ram_en;
    logic                     r_clk_mode, n_clk_mode;

    logic [15:0] addr;
    logic        is_write;
    logic        in_ram;
    logic        usable;
    logic [2:0]  ram_mask;
    logic [7:0]  rom_mask;
    logic [7:0]  rom_val;
    logic [20:0] ram_addr;
    logic [20:0] rom_addr;

    assign addr     = i_beat.bus_address;
    assign is_write = (i_beat.cmd == CMD_WRITE);
    assign in_ram   = (addr[15:13] == REGION_EXT_RAM);
    assign usable   = r_ram_en && !r_clk_mode
                   && ({1'b0, r_ram_bank} < 4'(RAM_BANK_LIMIT));

    // bank count is a power of two, so the wrap is a mask on the bank
    assign ram_mask = 3'((4'd1 << i_cfg.ram_bank_count_log2) - 4'd1);
    assign ram_addr = {5'd0, r_ram_bank & ram_mask, addr[12:0]};
    assign rom_addr = 21'({r_rom_bank, addr[13:0]});

    assign rom_mask = (8'd1 << i_cfg.rom_bank_count_log2) - 8'd1;
    assign rom_val  = i_beat.write_data & rom_mask;

    // result decode
    always_comb begin
        o_beat = '0;
        if (in_ram) begin
            if (is_write) begin
                if (usable) begin
                    o_beat.action         = ACT_RAM_WR;
                    o_beat.mapped_address = ram_addr;
                    o_beat.data_out       = i_beat.write_data;
                end else begin
                    o_beat.action = ACT_ABSORB;
                end
            end else if (usable) begin
                o_beat.action         = ACT_RAM_RD;
                o_beat.mapped_address = ram_addr;
            end else begin
                o_beat.action   = ACT_OPEN_RD;
                o_beat.data_out = OPEN_BUS_BYTE;
            end
        end else if (is_write) begin
            if (addr[15] == 1'b0) begin
                o_beat.action = ACT_ABSORB;
            end else begin
                o_beat.action         = ACT_BUS_WR;
                o_beat.mapped_address = 21'(addr);
                o_beat.data_out       = i_beat.write_data;
            end
        end else if (addr[15:14] == ROM_WINDOW) begin
            o_beat.action         = ACT_ROM_RD;
            o_beat.mapped_address = rom_addr;
        end else begin
            o_beat.action         = ACT_BUS_RD;
            o_beat.mapped_address = 21'(addr);
        end
    end

    // control register writes
    always_comb begin
        n_rom_bank = r_rom_bank;
        n_ram_bank = r_ram_bank;
        n_ram_en   = r_ram_en;
        n_clk_mode = r_clk_mode;
        if (i_fire && is_write && (addr[15] == 1'b0)) begin
            case (addr[15:13])
                REG_RAM_ENABLE: begin
                    n_ram_en = (i_beat.write_data[3:0] == RAM_EN_KEY);
                end
                REG_ROM_BANK: begin
                    if (i_beat.write_data == 8'd0) begin
                        n_rom_bank = ROM_BANK_BITS'(1);
                    end else begin
                        n_rom_bank = rom_val[ROM_BANK_BITS-1:0];
                    end
                end
                REG_RAM_BANK: begin
                    if (i_beat.write_data <= RAM_BANK_MAX) begin
                        n_clk_mode = 1'b0;
                        n_ram_bank = i_beat.write_data[2:0];
                    end else if (i_beat.write_data <= CLOCK_SEL_MAX) begin
                        n_clk_mode = 1'b1;
                    end
                end
                REG_LATCH: begin
                    // clock latch not implemented, write absorbed
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rom_bank <= ROM_BANK_BITS'(1);
            r_ram_bank <= 3'd0;
            r_ram_en   <= 1'b0;
            r_clk_mode <= 1'b0;
        end else begin
            r_rom_bank <= n_rom_bank;
            r_ram_bank <= n_ram_bank;
            r_ram_en   <= n_ram_en;
            r_clk_mode <= n_clk_mode;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/cartridge_bank_controller.sv =====
// ----------------------------------------------------------------------------
// cartridge_bank_controller: cartridge bank controller, clock chip left out
// maps cpu bus accesses to banked rom, banked external ram or the system bus
// ----------------------------------------------------------------------------
// usage
//   input channel: i_valid / o_stall carry one cpu access beat (cmd,
//   bus_address, write_data); a beat is taken when i_valid is high and
//   o_stall is low
//   output channel: o_valid / i_stall carry one result beat (action,
//   mapped_address, data_out) for every input beat, in order
//   the beat passes the input register, then the result register;
//   throughput: one beat per cycle while the receiver does not stall, set
//   by the combinational decode between the two registers
//   a bank register write takes effect for the very next beat
//   receiver stall: the result register holds; one more beat can wait in
//   the input register, after that o_stall rises until the receiver drains
//   reset (synchronous, i_rst_n low): both stages empty, rom bank 1, ram
//   bank 0, ram disabled, ram mode; rom count log2 7, ram count log2 0
//   apb port: reg 0 at 0x0 rom bank count log2, reg 1 at 0x4 ram bank count
//   log2; write only while the block is idle, pready is always high
// ----------------------------------------------------------------------------
`default_nettype none

module cartridge_bank_controller
    import cbc_pkg::*;
#(
    parameter int ROM_BANK_BITS  = 7,
    parameter int RAM_BANK_LIMIT = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // access channel
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire t_in_beat    i_data,
    // result channel
    output logic             o_valid,
    input  wire logic        i_stall,
    output t_out_beat        o_data,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // input stage
    logic      r_in_valid, n_in_valid;
    t_in_beat  r_in_beat;
    // result stage
    logic      r_out_valid, n_out_valid;
    t_out_beat r_out_beat;
    // configuration
    t_cfg      r_cfg, n_cfg;

    t_out_beat dec_beat;
    logic      advance;
    logic      fire;
    logic      cfg_wr;

    // result stage can take a new beat when empty or being drained
    assign advance = !r_out_valid || !i_stall;
    // input-stage beat moves to the result stage this cycle
    assign fire    = r_in_valid && advance;
    // full input stage with no room ahead blocks the sender
    assign o_stall = r_in_valid && !advance;

    assign o_valid = r_out_valid;
    assign o_data  = r_out_beat;

    // bank state and decode
    cbc_mapper #(
        .ROM_BANK_BITS  (ROM_BANK_BITS),
        .RAM_BANK_LIMIT (RAM_BANK_LIMIT)
    ) u_mapper (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_beat  (r_in_beat),
        .i_cfg   (r_cfg),
        .o_beat  (dec_beat)
    );

    always_comb begin
        n_in_valid  = r_in_valid;
        n_out_valid = r_out_valid;
        if (!o_stall) begin
            n_in_valid = i_valid;
        end
        if (advance) begin
            n_out_valid = r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_beat <= i_data;
        end
        if (fire) begin
            r_out_beat <= dec_beat;
        end
    end

    // apb register file, register index is paddr[2]
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        n_cfg = r_cfg;
        if (cfg_wr) begin
            case (paddr[2])
                CFG_ROM_LOG2: n_cfg.rom_bank_count_log2 = pwdata[2:0];
                CFG_RAM_LOG2: n_cfg.ram_bank_count_log2 = pwdata[1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rom_bank_count_log2 <= ROM_LOG2_RESET;
            r_cfg.ram_bank_count_log2 <= RAM_LOG2_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        case (paddr[2])
            CFG_ROM_LOG2: prdata = 32'(r_cfg.rom_bank_count_log2);
            CFG_RAM_LOG2: prdata = 32'(r_cfg.ram_bank_count_log2);
            default:      prdata = '0;
        endcase
    end

endmodule

`default_nettype wire
